// ----- hdl/kmsd_pkg.sv -----
package kmsd_pkg;

    // fixed field widths
    localparam int COL_W   = 4;
    localparam int LEVEL_W = 8;
    localparam int TIME_W  = 16;
    localparam int DEB_W   = 8;

    // default matrix geometry
    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 16;

    // configuration port
    localparam int              CFG_IDX_W   = 1;
    localparam int              CFG_DATA_W  = DEB_W;
    localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_MS  = 1'b0,
        REG_INVERT_SENSE = 1'b1
    } cfg_reg_t;

    // one column sample
    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [LEVEL_W-1:0] row_levels;
        logic               end_of_scan;
        logic [TIME_W-1:0]  now_ms;
    } item_t;

    // one result
    typedef struct packed {
        logic [LEVEL_W-1:0] stable_bits;
        logic               window_open;
        logic               stable_updated;
        logic               all_keys_off;
    } result_t;

    // configuration as seen by the core
    typedef struct packed {
        logic [DEB_W-1:0] debounce_ms;
        logic             invert_sense;
    } cfg_t;

endpackage

// ----- hdl/kmsd_in_stage.sv -----
module kmsd_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic            drain,
    input  kmsd_pkg::item_t item_in,
    output logic            item_valid,
    output kmsd_pkg::item_t item_out
);

    logic            valid_reg;
    logic            valid_next;
    kmsd_pkg::item_t item_reg;

    assign valid_next = load | (valid_reg & ~drain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

// ----- hdl/kmsd_core.sv -----
module kmsd_core
#(
    parameter int ROWS = kmsd_pkg::ROWS_DEF,
    parameter int COLS = kmsd_pkg::COLS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  kmsd_pkg::item_t   item,
    input  kmsd_pkg::cfg_t    cfg,
    output kmsd_pkg::result_t res
);

    localparam int CIDX_W = (COLS > 1) ? $clog2(COLS) : 1;

    logic [ROWS-1:0]   raw_reg    [COLS];
    logic [ROWS-1:0]   stable_reg [COLS];
    logic [ROWS-1:0]   raw_after  [COLS];
    logic [COLS-1:0]   raw_nz_reg;
    logic [COLS-1:0]   raw_nz_next;
    logic [COLS-1:0]   stable_nz_reg;
    logic              scan_changed_reg;
    logic              scan_changed_next;
    logic              win_active_reg;
    logic              win_active_next;
    logic [kmsd_pkg::TIME_W-1:0] win_start_reg;
    logic [kmsd_pkg::TIME_W-1:0] win_start_next;

    logic [CIDX_W-1:0] col_idx;
    logic              col_ok;
    logic [ROWS-1:0]   levels;
    logic              changed;
    logic              changed_eff;
    logic              open_now;
    logic              active_eff;
    logic [kmsd_pkg::TIME_W-1:0] elapsed;
    logic              copy;
    logic [ROWS-1:0]   col_bits;

    assign col_idx = CIDX_W'(item.column);
    assign col_ok  = (32'(item.column) < COLS);

    // widen first so that rows above the port still invert
    always_comb
    begin
        levels = ROWS'(item.row_levels);
        if (cfg.invert_sense)
        begin
            levels = ~levels;
        end
    end

    assign changed     = col_ok && (raw_reg[col_idx] != levels);
    assign changed_eff = scan_changed_reg | changed;

    always_comb
    begin
        for (int c = 0; c < COLS; c++)
        begin
            raw_after[c]   = raw_reg[c];
            raw_nz_next[c] = raw_nz_reg[c];
        end
        if (col_ok)
        begin
            raw_after[col_idx]   = levels;
            raw_nz_next[col_idx] = |levels;
        end
    end

    // global debounce window
    assign open_now       = item.end_of_scan & changed_eff & ~win_active_reg;
    assign active_eff     = win_active_reg | open_now;
    assign win_start_next = open_now ? item.now_ms : win_start_reg;
    assign elapsed        = item.now_ms - win_start_next;
    assign copy           = item.end_of_scan & active_eff &
                            (elapsed >= kmsd_pkg::TIME_W'(cfg.debounce_ms));

    assign win_active_next   = item.end_of_scan ? (active_eff & ~copy) : win_active_reg;
    assign scan_changed_next = item.end_of_scan ? 1'b0 : changed_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                raw_reg[c]    <= '0;
                stable_reg[c] <= '0;
            end
            raw_nz_reg       <= '0;
            stable_nz_reg    <= '0;
            scan_changed_reg <= 1'b0;
            win_active_reg   <= 1'b0;
            win_start_reg    <= '0;
        end
        else if (fire)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                raw_reg[c] <= raw_after[c];
                if (copy)
                begin
                    stable_reg[c] <= raw_after[c];
                end
            end
            raw_nz_reg <= raw_nz_next;
            if (copy)
            begin
                stable_nz_reg <= raw_nz_next;
            end
            scan_changed_reg <= scan_changed_next;
            win_active_reg   <= win_active_next;
            win_start_reg    <= win_start_next;
        end
    end

    // column read after this item's update
    always_comb
    begin
        col_bits = '0;
        if (col_ok)
        begin
            col_bits = copy ? levels : stable_reg[col_idx];
        end
    end

    assign res.stable_bits    = kmsd_pkg::LEVEL_W'(col_bits);
    assign res.window_open    = win_active_next;
    assign res.stable_updated = copy;
    assign res.all_keys_off   = copy ? ~|raw_nz_next : ~|stable_nz_reg;

    a_copy_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.stable_updated |-> !res.window_open)
        else $error("window still open after copy");

    a_window_only_at_eos: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.end_of_scan |=> win_active_reg == $past(win_active_reg))
        else $error("window moved on a mid-scan item");

    a_change_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.end_of_scan |=> !scan_changed_reg)
        else $error("change note survived end of scan");

    a_stable_follows_raw: assert property (@(posedge clk) disable iff (!rst_n)
        fire && copy |=> stable_nz_reg == raw_nz_reg)
        else $error("stable summary differs from raw after copy");

endmodule

// ----- hdl/key_matrix_scan_global_debounce_unit.sv -----
// path: an accepted item is registered in the input register, and its result item is
//   registered in the result register, from which it can be taken
// throughput: one item per cycle unless out_stall holds the result register; the matrix
//   and window update in a single pass between the input register and the result register
// reset: rst_n asynchronous, active low; clears the raw and stable matrices,
//   the change note and the window, debounce_ms returns to 5, invert_sense to 0
module key_matrix_scan_global_debounce_unit
#(
    parameter int ROWS = kmsd_pkg::ROWS_DEF,
    parameter int COLS = kmsd_pkg::COLS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_write,
    input  logic [kmsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kmsd_pkg::CFG_DATA_W-1:0]   cfg_data,

    // column sample items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kmsd_pkg::COL_W-1:0]        column,
    input  logic [kmsd_pkg::LEVEL_W-1:0]      row_levels,
    input  logic                              end_of_scan,
    input  logic [kmsd_pkg::TIME_W-1:0]       now_ms,

    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kmsd_pkg::LEVEL_W-1:0]      stable_bits,
    output logic                              window_open,
    output logic                              stable_updated,
    output logic                              all_keys_off
);

    // configuration registers
    logic [kmsd_pkg::DEB_W-1:0] debounce_ms_reg;
    logic                       invert_sense_reg;
    kmsd_pkg::cfg_t             cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg  <= kmsd_pkg::DEBOUNCE_RST;
            invert_sense_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                kmsd_pkg::REG_DEBOUNCE_MS:  debounce_ms_reg  <= cfg_data;
                kmsd_pkg::REG_INVERT_SENSE: invert_sense_reg <= cfg_data[0];
            endcase
        end
    end

    assign cfg.debounce_ms  = debounce_ms_reg;
    assign cfg.invert_sense = invert_sense_reg;

    // handshake: the result register frees up when empty or when taken; a result held
    // under out_stall keeps the input register from draining, and a full one stalls input
    kmsd_pkg::item_t   item_in;
    kmsd_pkg::item_t   item_s1;
    logic              s1_valid;
    logic              out_ready;
    logic              fire;
    logic              accept;
    kmsd_pkg::result_t res;
    kmsd_pkg::result_t res_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign item_in.column      = column;
    assign item_in.row_levels  = row_levels;
    assign item_in.end_of_scan = end_of_scan;
    assign item_in.now_ms      = now_ms;

    assign out_ready = ~out_valid_reg | ~out_stall;
    assign fire      = s1_valid & out_ready;
    assign in_stall  = s1_valid & ~out_ready;
    assign accept    = in_valid & ~in_stall;

    kmsd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .drain      (fire),
        .item_in    (item_in),
        .item_valid (s1_valid),
        .item_out   (item_s1)
    );

    // matrix state, window logic and result formation
    kmsd_core
    #(
        .ROWS (ROWS),
        .COLS (COLS)
    )
    u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_s1),
        .cfg   (cfg),
        .res   (res)
    );

    // result register
    assign out_valid_next = fire | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stable_bits    = res_reg.stable_bits;
    assign window_open    = res_reg.window_open;
    assign stable_updated = res_reg.stable_updated;
    assign all_keys_off   = res_reg.all_keys_off;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !fire)
        else $error("result overwritten while held");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !fire |-> in_stall)
        else $error("input accepted over a waiting item");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule
